/* rtl/core/i2cmra_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmra_pkg
// Shared types and constants of the I2C register access unit.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned OutDataW  = 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_PHASE_TICKS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd5;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  typedef enum logic [1:0] {
    K_TICK,
    K_WRITE,
    K_READ,
    K_NONE
  } kind_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_RS_PREP, PH_S_HIGH, PH_S_FALL, PH_S_LOW,
    PH_BIT_LOW, PH_BIT_HIGH, PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_END,
    PH_RD_LOW, PH_RD_HIGH, PH_NACK_LOW, PH_NACK_HIGH,
    PH_SP_LOW, PH_SP_HIGH, PH_SP_END
  } ph_e;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] dev;
    logic [7:0] regaddr;
    logic [7:0] data;
    logic       sda;
  } req_t;

  typedef struct packed {
    logic       rejected;
    logic       ack_error;
    logic [7:0] read_data;
    logic       done;
    logic       busy;
    logic       sda_en;
    logic       sda_out;
    logic       scl;
  } res_t;

endpackage
`default_nettype wire

/* rtl/core/i2cmra_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmra_front
// Takes requests from the input stream and classifies the operation code.
// ----------------------------------------------------------------------------
module i2cmra_front (
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [i2cmra_pkg::InDataW-1:0] s_axis_tdata,
  input  wire logic [i2cmra_pkg::InUserW-1:0] s_axis_tuser,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output i2cmra_pkg::req_t                   req_o
);
  import i2cmra_pkg::*;

  kind_e kind;

  always_comb begin
    unique case (s_axis_tuser)
      OP_TICK:  kind = K_TICK;
      OP_WRITE: kind = K_WRITE;
      OP_READ:  kind = K_READ;
      default:  kind = K_NONE;
    endcase
  end

  assign s_axis_tready = ~q_full_i;
  assign push_o        = s_axis_tvalid & ~q_full_i;

  assign req_o.kind    = kind;
  assign req_o.dev     = s_axis_tdata[6:0];
  assign req_o.regaddr = s_axis_tdata[14:7];
  assign req_o.data    = s_axis_tdata[22:15];
  assign req_o.sda     = s_axis_tdata[23];

endmodule
`default_nettype wire

/* rtl/core/i2cmra_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmra_queue
// Two-entry request queue between the front and the bus sequencer.
// ----------------------------------------------------------------------------
module i2cmra_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire i2cmra_pkg::req_t req_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output i2cmra_pkg::req_t      req_o
);
  import i2cmra_pkg::*;

  req_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign req_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= req_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/i2cmra_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmra_back
// Bus phase sequencer, configuration registers and output register.
// ----------------------------------------------------------------------------
module i2cmra_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [i2cmra_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [i2cmra_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                           q_valid_i,
  input  wire i2cmra_pkg::req_t               req_i,
  output logic                                pop_o,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output i2cmra_pkg::res_t                    res_o
);
  import i2cmra_pkg::*;

  logic [15:0] pt_q;
  logic [7:0]  at_q;

  ph_e         ph_q, ph_d;
  logic [16:0] pcnt_q, pcnt_d;
  logic [3:0]  bcnt_q, bcnt_d;
  logic [1:0]  bidx_q, bidx_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  await_q, await_d;
  logic        rd_q, rd_d;
  logic [6:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic [7:0]  dat_q, dat_d;
  logic [7:0]  rx_q, rx_d;
  logic        abort_q, abort_d;
  logic        ovalid_q, ovalid_d;
  res_t        out_q, out_d;

  logic        done, rej;
  logic [15:0] slen;
  logic [16:0] plen;
  logic [16:0] pcnt_inc;
  logic [3:0]  bcnt_inc;
  logic [7:0]  await_inc;
  logic [2:0]  lv;

  function automatic logic [7:0] load_byte(logic [1:0] bi, logic isr,
                                           logic [6:0] dv, logic [7:0] rg,
                                           logic [7:0] dt);
    logic [7:0] b;
    priority if (bi == 2'd0) b = {dv, 1'b0};
    else if (bi == 2'd1)     b = rg;
    else if (!isr)           b = dt;
    else                     b = {dv, 1'b1};
    return b;
  endfunction

  // {SCL, SDA, enable}
  function automatic logic [2:0] levels(ph_e ph, logic b);
    logic [2:0] l;
    unique case (ph)
      PH_RS_PREP:                       l = 3'b011;
      PH_S_FALL:                        l = 3'b101;
      PH_S_LOW:                         l = 3'b001;
      PH_BIT_LOW:                       l = {1'b0, b, 1'b1};
      PH_BIT_HIGH:                      l = {1'b1, b, 1'b1};
      PH_ACK_LOW, PH_ACK_END, PH_RD_LOW: l = 3'b010;
      PH_ACK_HIGH, PH_RD_HIGH:          l = 3'b110;
      PH_NACK_LOW:                      l = 3'b011;
      PH_SP_LOW:                        l = 3'b001;
      PH_SP_HIGH:                       l = 3'b101;
      default:                          l = 3'b111;
    endcase
    return l;
  endfunction

  assign pop_o = q_valid_i & (~ovalid_q | m_axis_tready);

  always_comb begin
    slen = (pt_q == 16'd0) ? 16'd1 : pt_q;
    unique case (ph_q)
      PH_RS_PREP, PH_S_HIGH, PH_S_FALL, PH_S_LOW,
      PH_SP_LOW, PH_SP_HIGH, PH_SP_END: plen = {slen, 1'b0};
      default:                          plen = {1'b0, slen};
    endcase
    pcnt_inc  = pcnt_q + 17'd1;
    bcnt_inc  = bcnt_q + 4'd1;
    await_inc = (await_q != 8'hFF) ? (await_q + 8'd1) : await_q;
  end

  always_comb begin
    ph_d    = ph_q;
    pcnt_d  = pcnt_q;
    bcnt_d  = bcnt_q;
    bidx_d  = bidx_q;
    shift_d = shift_q;
    await_d = await_q;
    rd_d    = rd_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    dat_d   = dat_q;
    rx_d    = rx_q;
    abort_d = abort_q;
    done    = 1'b0;
    rej     = 1'b0;

    if (pop_o) begin
      unique case (req_i.kind)
        K_WRITE, K_READ: begin
          if (ph_q != PH_IDLE) begin
            rej = 1'b1;
          end else begin
            dev_d   = req_i.dev;
            reg_d   = req_i.regaddr;
            dat_d   = req_i.data;
            rd_d    = (req_i.kind == K_READ);
            bidx_d  = 2'd0;
            bcnt_d  = 4'd0;
            shift_d = 8'd0;
            await_d = 8'd0;
            pcnt_d  = 17'd0;
            abort_d = 1'b0;
            ph_d    = PH_S_HIGH;
          end
        end
        K_TICK: begin
          if (ph_q == PH_ACK_HIGH) begin
            if (pcnt_q < {1'b0, slen}) begin
              pcnt_d = pcnt_inc;
            end else if (!req_i.sda) begin
              pcnt_d = 17'd0;
              ph_d   = PH_ACK_END;
            end else begin
              await_d = await_inc;
              if (await_inc >= at_q) begin
                abort_d = 1'b1;
                pcnt_d  = 17'd0;
                ph_d    = PH_SP_LOW;
              end
            end
          end else if (ph_q != PH_IDLE) begin
            pcnt_d = pcnt_inc;
            if (pcnt_inc >= plen) begin
              pcnt_d = 17'd0;
              unique case (ph_q)
                PH_RS_PREP: ph_d = PH_S_HIGH;
                PH_S_HIGH:  ph_d = PH_S_FALL;
                PH_S_FALL:  ph_d = PH_S_LOW;
                PH_S_LOW: begin
                  shift_d = load_byte(bidx_q, rd_q, dev_q, reg_q, dat_q);
                  bcnt_d  = 4'd0;
                  ph_d    = PH_BIT_LOW;
                end
                PH_BIT_LOW: ph_d = PH_BIT_HIGH;
                PH_BIT_HIGH: begin
                  shift_d = {shift_q[6:0], 1'b0};
                  if (bcnt_inc >= 4'd8) begin
                    bcnt_d  = 4'd0;
                    await_d = 8'd0;
                    ph_d    = PH_ACK_LOW;
                  end else begin
                    bcnt_d = bcnt_inc;
                    ph_d   = PH_BIT_LOW;
                  end
                end
                PH_ACK_LOW: ph_d = PH_ACK_HIGH;
                PH_ACK_END: begin
                  if (!rd_q) begin
                    if (bidx_q < 2'd2) begin
                      bidx_d  = bidx_q + 2'd1;
                      shift_d = load_byte(bidx_q + 2'd1, rd_q, dev_q, reg_q, dat_q);
                      bcnt_d  = 4'd0;
                      ph_d    = PH_BIT_LOW;
                    end else begin
                      ph_d = PH_SP_LOW;
                    end
                  end else if (bidx_q == 2'd0) begin
                    bidx_d  = 2'd1;
                    shift_d = load_byte(2'd1, rd_q, dev_q, reg_q, dat_q);
                    bcnt_d  = 4'd0;
                    ph_d    = PH_BIT_LOW;
                  end else if (bidx_q == 2'd1) begin
                    bidx_d = 2'd2;
                    ph_d   = PH_RS_PREP;
                  end else begin
                    shift_d = 8'd0;
                    bcnt_d  = 4'd0;
                    ph_d    = PH_RD_LOW;
                  end
                end
                PH_RD_LOW: ph_d = PH_RD_HIGH;
                PH_RD_HIGH: begin
                  shift_d = {shift_q[6:0], req_i.sda};
                  if (bcnt_inc >= 4'd8) begin
                    bcnt_d = 4'd0;
                    ph_d   = PH_NACK_LOW;
                  end else begin
                    bcnt_d = bcnt_inc;
                    ph_d   = PH_RD_LOW;
                  end
                end
                PH_NACK_LOW:  ph_d = PH_NACK_HIGH;
                PH_NACK_HIGH: ph_d = PH_SP_LOW;
                PH_SP_LOW:    ph_d = PH_SP_HIGH;
                PH_SP_HIGH:   ph_d = PH_SP_END;
                PH_SP_END: begin
                  if (rd_q && !abort_q) begin
                    rx_d = shift_q;
                  end
                  done = 1'b1;
                  ph_d = PH_IDLE;
                end
                default: ph_d = PH_IDLE;
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    lv                = levels(ph_d, shift_d[7]);
    out_d             = out_q;
    if (pop_o) begin
      out_d.scl       = lv[2];
      out_d.sda_out   = lv[1];
      out_d.sda_en    = lv[0];
      out_d.busy      = (ph_d != PH_IDLE);
      out_d.done      = done;
      out_d.read_data = rx_d;
      out_d.ack_error = done & abort_d;
      out_d.rejected  = rej;
    end
    ovalid_d = pop_o | (ovalid_q & ~m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q     <= PHASE_TICKS_RST;
      at_q     <= ACK_TIMEOUT_RST;
      ph_q     <= PH_IDLE;
      pcnt_q   <= 17'd0;
      bcnt_q   <= 4'd0;
      bidx_q   <= 2'd0;
      shift_q  <= 8'd0;
      await_q  <= 8'd0;
      rd_q     <= 1'b0;
      dev_q    <= 7'd0;
      reg_q    <= 8'd0;
      dat_q    <= 8'd0;
      rx_q     <= 8'd0;
      abort_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PHASE_TICKS: pt_q <= cfg_wdata_i;
          CFG_ACK_TIMEOUT: at_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      ph_q     <= ph_d;
      pcnt_q   <= pcnt_d;
      bcnt_q   <= bcnt_d;
      bidx_q   <= bidx_d;
      shift_q  <= shift_d;
      await_q  <= await_d;
      rd_q     <= rd_d;
      dev_q    <= dev_d;
      reg_q    <= reg_d;
      dat_q    <= dat_d;
      rx_q     <= rx_d;
      abort_q  <= abort_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign res_o         = out_q;

endmodule
`default_nettype wire

/* rtl/core/i2c_master_register_access_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_register_access_unit
// I2C master for single-byte register writes and reads, stepped by ticks.
// ----------------------------------------------------------------------------
// Requests come in on s_axis: tuser carries the operation (tick, register
// write, register read), tdata the device address, register address, write
// data and the SDA level sampled for the tick. Each request gives exactly one
// response on m_axis with the SCL/SDA pin levels and the transfer status.
// The cfg port sets phase_ticks (index 0) and ack_timeout (index 1); write it
// only while no transfer runs.
// A request passes a two-entry queue and the sequencer; its response is held
// in the output register. One request per cycle is sustained while m_axis
// does not stall.
// When m_axis stalls the response is held in the output register, the queue
// fills and s_axis_tready drops after two more requests.
// Reset returns the sequencer to idle, loads the default register values and
// empties the queue and the output register; its pin levels are not reset.
// ----------------------------------------------------------------------------
module i2c_master_register_access_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [i2cmra_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [i2cmra_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // device_address[6:0], register_address[14:7], write_data[22:15], sda_level[23]
  input  wire logic [i2cmra_pkg::InDataW-1:0]  s_axis_tdata,
  // operation[1:0]
  input  wire logic [i2cmra_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // scl_level[0], sda_out[1], sda_enable[2], busy_res[3], done_res[4],
  // read_data[12:5], ack_error[13], command_rejected[14], zero[15]
  output logic [i2cmra_pkg::OutDataW-1:0]      m_axis_tdata
);
  import i2cmra_pkg::*;

  req_t fr_req, q_req;
  logic q_full, q_valid, push, pop;
  res_t res;

  i2cmra_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .req_o         (fr_req)
  );

  i2cmra_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (fr_req),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .req_o   (q_req)
  );

  i2cmra_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .req_i         (q_req),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (res)
  );

  assign m_axis_tdata = {1'b0, res};

endmodule
`default_nettype wire

/* rtl/core/i2cmra_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmra_checker
// Port-level checks of the I2C register access unit.
// ----------------------------------------------------------------------------
module i2cmra_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [i2cmra_pkg::OutDataW-1:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("response changed while stalled");

  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tdata[4])
    else $error("ack_error without done");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3] && (m_axis_tdata[2:0] == 3'b111))
    else $error("done while bus not idle");

  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tdata[3])
    else $error("rejected command while idle");

  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[1])
    else $error("released SDA not high");

endmodule

bind i2c_master_register_access_unit i2cmra_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
